[design/wmv_pkg.sv]
package wmv_pkg;

    // default number of orientation classes
    localparam int NUM_CLASSES_DEF = 6;

    // field widths
    localparam int ORIENT_W = 4;
    localparam int COUNT_W  = 8;
    localparam int LENGTH_W = 8;

    // reset value of the window length register
    localparam logic [LENGTH_W-1:0] WINDOW_LENGTH_RESET = 8'd8;

    // largest vote count, counters saturate here
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // code given when a window closes with no votes (-1)
    localparam logic [ORIENT_W-1:0] NO_CLASS = {ORIENT_W{1'b1}};

    // one result item
    typedef struct packed {
        logic [ORIENT_W-1:0] filtered;
        logic                done;
    } result_t;

endpackage

[design/wmv_majority.sv]
module wmv_majority #(
    parameter int NUM_CLASSES = wmv_pkg::NUM_CLASSES_DEF
) (
    input  logic [wmv_pkg::COUNT_W-1:0]  counts [NUM_CLASSES],
    output logic [wmv_pkg::ORIENT_W-1:0] winner
);

    // strict greater keeps the lowest index on a tie
    always_comb begin
        logic [wmv_pkg::COUNT_W-1:0] best_count;
        best_count = '0;
        winner     = wmv_pkg::NO_CLASS;
        for (int k = 0; k < NUM_CLASSES; k++) begin
            if (counts[k] > best_count) begin
                best_count = counts[k];
                winner     = wmv_pkg::ORIENT_W'(k);
            end
        end
    end

endmodule

[design/wmv_vote_bank.sv]
module wmv_vote_bank #(
    parameter int NUM_CLASSES = wmv_pkg::NUM_CLASSES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_fire,
    input  logic [wmv_pkg::ORIENT_W-1:0]  orientation,
    input  logic [wmv_pkg::LENGTH_W-1:0]  window_length,
    output wmv_pkg::result_t              result_next
);

    logic [wmv_pkg::COUNT_W-1:0]  counts_reg  [NUM_CLASSES];
    logic [wmv_pkg::COUNT_W-1:0]  counts_vote [NUM_CLASSES];
    logic [wmv_pkg::LENGTH_W-1:0] position_reg;
    logic [wmv_pkg::LENGTH_W-1:0] position_inc;
    logic                         started_reg;
    logic [wmv_pkg::ORIENT_W-1:0] held_reg;
    logic [wmv_pkg::ORIENT_W-1:0] held_next;
    logic [wmv_pkg::ORIENT_W-1:0] winner;
    logic                         is_vote;
    logic                         close;

    // sign bit clear and below the class count
    assign is_vote = !orientation[wmv_pkg::ORIENT_W-1]
                     && (32'(orientation) < NUM_CLASSES);

    always_comb begin
        for (int k = 0; k < NUM_CLASSES; k++) begin
            counts_vote[k] = counts_reg[k];
            if (is_vote && orientation == wmv_pkg::ORIENT_W'(k)
                && counts_reg[k] != wmv_pkg::COUNT_MAX) begin
                counts_vote[k] = counts_reg[k] + 1'b1;
            end
        end
    end

    wmv_majority #(
        .NUM_CLASSES (NUM_CLASSES)
    ) u_majority (
        .counts (counts_vote),
        .winner (winner)
    );

    assign position_inc = position_reg + 1'b1;
    assign close        = (position_inc == window_length);

    always_comb begin
        held_next = held_reg;
        if (!started_reg) begin
            held_next = orientation;
        end
        if (close) begin
            held_next = winner;
        end
    end

    assign result_next.filtered = held_next;
    assign result_next.done     = close;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NUM_CLASSES; k++) begin
                counts_reg[k] <= '0;
            end
            position_reg <= '0;
            started_reg  <= 1'b0;
            held_reg     <= '0;
        end else if (in_fire) begin
            for (int k = 0; k < NUM_CLASSES; k++) begin
                counts_reg[k] <= close ? '0 : counts_vote[k];
            end
            position_reg <= close ? '0 : position_inc;
            started_reg  <= 1'b1;
            held_reg     <= held_next;
        end
    end

endmodule

[design/windowed_majority_vote_top.sv]
// Windowed majority vote (mode filter) over orientation readings. Each input
// transaction carries one reading, a class 0 to NUM_CLASSES-1 or -1 for none,
// and gives exactly one result transaction with the held class and a flag set
// when that reading closed a window. The first reading after reset is passed
// straight to the output (whatever its value) and also votes. Once
// window_length readings have been seen the output becomes the class with the
// most votes (lowest index on a tie, -1 with no votes) and the votes clear; a
// window length of zero means 256 readings. One reading is taken every clock
// cycle while the result side keeps up: the vote update and the class compare
// sit between the state registers and a single output register, so each result
// is registered in the cycle after its reading is taken.
// window_length is written through the cfg channel, which is always ready;
// write it only while no transaction is in flight.
module windowed_majority_vote_top #(
    parameter int NUM_CLASSES = wmv_pkg::NUM_CLASSES_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [wmv_pkg::LENGTH_W-1:0]        cfg_data,
    // reading channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [wmv_pkg::ORIENT_W-1:0] s_orientation,
    // result channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [wmv_pkg::ORIENT_W-1:0] m_filtered_orientation,
    output logic                                m_window_done
);

    logic [wmv_pkg::LENGTH_W-1:0] window_length_reg;
    logic                         in_fire;
    wmv_pkg::result_t             result_next;
    logic                         m_valid_reg;
    wmv_pkg::result_t             m_result_reg;

    // config register, always accepts a write
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_length_reg <= wmv_pkg::WINDOW_LENGTH_RESET;
        end else if (cfg_valid) begin
            window_length_reg <= cfg_data;
        end
    end

    // take a reading whenever the output register is empty or draining
    assign s_ready = !m_valid_reg || m_ready;
    assign in_fire = s_valid && s_ready;

    // vote counters, window position and held class
    wmv_vote_bank #(
        .NUM_CLASSES (NUM_CLASSES)
    ) u_vote_bank (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_fire       (in_fire),
        .orientation   (s_orientation),
        .window_length (window_length_reg),
        .result_next   (result_next)
    );

    // output register, valid flag under reset, payload loads on each transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            m_result_reg <= result_next;
        end
    end

    assign m_valid                = m_valid_reg;
    assign m_filtered_orientation = m_result_reg.filtered;
    assign m_window_done          = m_result_reg.done;

endmodule

[sim/windowed_majority_vote_top_tb.sv]
`timescale 1ns / 1ps

module windowed_majority_vote_top_tb;

    localparam int CLASSES     = wmv_pkg::NUM_CLASSES_DEF;
    localparam int DIR_ROWS    = 24;
    localparam int HOLD_CYCLES = 60;
    localparam int MAX_REPORTS = 10;

    // one row of the directed stimulus, expectation typed in only where typed is set
    typedef struct packed {
        logic [wmv_pkg::ORIENT_W-1:0] orient;
        logic                         typed;
        logic [wmv_pkg::ORIENT_W-1:0] filtered;
        logic                         done;
    } dir_row_t;

    logic                                aclk                   = 1'b0;
    logic                                aresetn                = 1'b0;
    logic                                cfg_valid              = 1'b0;
    logic                                cfg_ready;
    logic [wmv_pkg::LENGTH_W-1:0]        cfg_data               = wmv_pkg::WINDOW_LENGTH_RESET;
    logic                                s_valid                = 1'b0;
    logic                                s_ready;
    logic signed [wmv_pkg::ORIENT_W-1:0] s_orientation          = '0;
    logic                                m_valid;
    logic                                m_ready                = 1'b0;
    logic signed [wmv_pkg::ORIENT_W-1:0] m_filtered_orientation;
    logic                                m_window_done;

    windowed_majority_vote_top dut (
        .aclk                   (aclk),
        .aresetn                (aresetn),
        .cfg_valid              (cfg_valid),
        .cfg_ready              (cfg_ready),
        .cfg_data               (cfg_data),
        .s_valid                (s_valid),
        .s_ready                (s_ready),
        .s_orientation          (s_orientation),
        .m_valid                (m_valid),
        .m_ready                (m_ready),
        .m_filtered_orientation (m_filtered_orientation),
        .m_window_done          (m_window_done)
    );

    // predictor copy of the voting state
    logic [wmv_pkg::COUNT_W-1:0]  vote_tally [CLASSES];
    logic [wmv_pkg::LENGTH_W-1:0] win_pos;
    logic [wmv_pkg::LENGTH_W-1:0] win_len;
    bit                           seen_first;
    logic [wmv_pkg::ORIENT_W-1:0] held_class;

    // expected results in order of the readings that caused them
    wmv_pkg::result_t pending_results [$];
    dir_row_t         directed_rows [DIR_ROWS];

    // idle percentages of the two sides, changed between phases
    int send_idle_pct = 29;
    int recv_idle_pct = 58;

    // long receiver hold-off requests, served by the receiver process
    int hold_reqs = 0;

    int mismatches     = 0;
    int readings_sent  = 0;
    int results_seen   = 0;
    int windows_closed = 0;

    // 2 ns clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function void clear_tally();
        for (int k = 0; k < CLASSES; k++) begin
            vote_tally[k] = '0;
        end
    endfunction

    // most votes wins, lowest index on a tie, no votes gives the no-class code
    function logic [wmv_pkg::ORIENT_W-1:0] majority_class();
        logic [wmv_pkg::COUNT_W-1:0]  best_count;
        logic [wmv_pkg::ORIENT_W-1:0] best;
        best_count = '0;
        best       = wmv_pkg::NO_CLASS;
        for (int k = 0; k < CLASSES; k++) begin
            if (vote_tally[k] > best_count) begin
                best_count = vote_tally[k];
                best       = wmv_pkg::ORIENT_W'(k);
            end
        end
        return best;
    endfunction

    // advance the predictor by one accepted reading
    function wmv_pkg::result_t predict_reading(input logic [wmv_pkg::ORIENT_W-1:0] reading);
        wmv_pkg::result_t res;
        if (!seen_first) begin
            // first reading after reset goes straight out, raw bits and all
            held_class = reading;
            seen_first = 1'b1;
        end
        if (!reading[wmv_pkg::ORIENT_W-1] && reading < CLASSES) begin
            if (vote_tally[reading] != wmv_pkg::COUNT_MAX) begin
                vote_tally[reading] = vote_tally[reading] + 1'b1;
            end
        end
        // 8-bit position wraps, so a length of zero means 256 readings
        win_pos  = win_pos + 1'b1;
        res.done = 1'b0;
        if (win_pos == win_len) begin
            held_class = majority_class();
            clear_tally();
            win_pos  = '0;
            res.done = 1'b1;
        end
        res.filtered = held_class;
        return res;
    endfunction

    // mostly real votes leaning to one class, some no-reading and raw noise
    function logic [wmv_pkg::ORIENT_W-1:0] random_reading(input int favored);
        int pick;
        pick = $urandom_range(99);
        if (pick < 45) begin
            return wmv_pkg::ORIENT_W'(favored);
        end else if (pick < 80) begin
            return wmv_pkg::ORIENT_W'($urandom_range(CLASSES - 1));
        end else if (pick < 90) begin
            return wmv_pkg::NO_CLASS;
        end else begin
            return wmv_pkg::ORIENT_W'($urandom_range(15));
        end
    endfunction

    task automatic note_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("mismatch at %0t: %s", $realtime, what);
        end
    endtask

    // offer one reading, wait for its transaction, then record the expectation
    task automatic send_reading(input logic [wmv_pkg::ORIENT_W-1:0] reading, input bit typed,
                                input wmv_pkg::result_t typed_res);
        wmv_pkg::result_t predicted;
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_orientation <= reading;
        do @(posedge aclk); while (!s_ready);
        predicted = predict_reading(reading);
        pending_results.push_back(typed ? typed_res : predicted);
        readings_sent++;
    endtask

    task automatic run_random(input int count, input int favored);
        for (int i = 0; i < count; i++) begin
            send_reading(random_reading(favored), 1'b0, '0);
        end
    endtask

    // sender goes quiet until every expected result has come back
    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    // register write only with the block idle
    task automatic write_window_length(input logic [wmv_pkg::LENGTH_W-1:0] len);
        drain_results();
        repeat (3) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= len;
        do @(posedge aclk); while (!cfg_ready);
        win_len = len;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // receiver: random stalls, plus a long hold-off when one is requested
    always @(negedge aclk) begin : result_sink
        int served;
        int hold_left;
        if (served != hold_reqs) begin
            served    = served + 1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // result checker, oldest expectation first
    always @(posedge aclk) begin : result_check
        wmv_pkg::result_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (m_window_done === 1'b1) begin
                windows_closed++;
            end
            if (pending_results.size() == 0) begin
                note_mismatch($sformatf("result with nothing expected: filtered %0d done %0b",
                                        m_filtered_orientation, m_window_done));
            end else begin
                want = pending_results.pop_front();
                if (m_filtered_orientation !== want.filtered || m_window_done !== want.done) begin
                    note_mismatch($sformatf("expected filtered %0d done %0b, got %0d done %0b",
                                            $signed(want.filtered), want.done,
                                            m_filtered_orientation, m_window_done));
                end
            end
        end
    end

    // hard stop in case the block hangs
    initial begin
        #500000;
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin : stimulus
        dir_row_t                     row;
        wmv_pkg::result_t             typed_res;
        logic [wmv_pkg::LENGTH_W-1:0] len;

        win_len    = wmv_pkg::WINDOW_LENGTH_RESET;
        win_pos    = '0;
        seen_first = 1'b0;
        held_class = '0;
        clear_tally();

        // window of 8 from reset: first reading is out of range and passes
        // straight out, then a tied window, an empty window and a plain one
        directed_rows = '{
            '{4'sd7,  1'b1, 4'd7,              1'b0},
            '{4'sd0,  1'b0, 4'd0,              1'b0},
            '{4'sd0,  1'b0, 4'd0,              1'b0},
            '{4'sd5,  1'b0, 4'd0,              1'b0},
            '{4'sd5,  1'b0, 4'd0,              1'b0},
            '{-4'sd8, 1'b0, 4'd0,              1'b0},
            '{4'sd6,  1'b0, 4'd0,              1'b0},
            '{-4'sd1, 1'b1, 4'd0,              1'b1},
            '{-4'sd1, 1'b0, 4'd0,              1'b0},
            '{-4'sd2, 1'b0, 4'd0,              1'b0},
            '{4'sd6,  1'b0, 4'd0,              1'b0},
            '{4'sd7,  1'b0, 4'd0,              1'b0},
            '{-4'sd8, 1'b0, 4'd0,              1'b0},
            '{-4'sd1, 1'b0, 4'd0,              1'b0},
            '{-4'sd3, 1'b0, 4'd0,              1'b0},
            '{-4'sd4, 1'b1, wmv_pkg::NO_CLASS, 1'b1},
            '{4'sd5,  1'b0, 4'd0,              1'b0},
            '{4'sd4,  1'b0, 4'd0,              1'b0},
            '{4'sd4,  1'b0, 4'd0,              1'b0},
            '{4'sd3,  1'b0, 4'd0,              1'b0},
            '{4'sd2,  1'b0, 4'd0,              1'b0},
            '{4'sd1,  1'b0, 4'd0,              1'b0},
            '{4'sd4,  1'b0, 4'd0,              1'b0},
            '{-4'sd1, 1'b0, 4'd0,              1'b0}
        };

        // synchronous reset, released on a falling edge
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++) begin
            row                = directed_rows[i];
            typed_res.filtered = row.filtered;
            typed_res.done     = row.done;
            send_reading(row.orient, row.typed, typed_res);
        end

        // length zero: 256 votes for one class, its counter must saturate, not wrap,
        // then a few readings into the next window
        write_window_length('0);
        repeat (256) send_reading(wmv_pkg::ORIENT_W'(1), 1'b0, '0);
        run_random(6, 3);

        // length drops below the current position: wraps through zero first
        send_idle_pct = 58;
        recv_idle_pct = 29;
        write_window_length(wmv_pkg::LENGTH_W'(2));
        run_random(256, 5);

        for (int p = 0; p < 6; p++) begin
            if (p == 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (p == 0) begin
                len = wmv_pkg::LENGTH_W'(1);
            end else if ($urandom_range(3) == 0) begin
                len = wmv_pkg::LENGTH_W'($urandom_range(255));
            end else begin
                len = wmv_pkg::LENGTH_W'($urandom_range(12, 1));
            end
            write_window_length(len);
            if (p == 3) begin
                // receiver holds off while readings keep coming, so the block backs up
                hold_reqs++;
            end
            if (p == 5) begin
                run_random(8, p);
                drain_results();
                run_random(7, p);
            end else begin
                run_random(15, p);
            end
        end

        drain_results();
        repeat (4) @(posedge aclk);

        $display("%0d readings sent, %0d results checked, %0d windows closed",
                 readings_sent, results_seen, windows_closed);
        $display("window lengths 0, 1, 2 and random, saturation, wrap, hold-off and drain");
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
